/* hdl/ihp_pkg.sv */
// ----------------------------------------------------------------------------
// ihp_pkg
// Shared types and constants for the image header probe.
// ----------------------------------------------------------------------------
package ihp_pkg;

	localparam int HdrBytes = 30;
	localparam logic [5:0] PosSat = 6'd31;

	typedef enum logic [2:0] {
		FMT_NONE = 3'd0,
		FMT_PNG  = 3'd1,
		FMT_JPEG = 3'd2,
		FMT_GIF  = 3'd3,
		FMT_BMP  = 3'd4,
		FMT_WEBP = 3'd5,
		FMT_TIFF = 3'd6
	} fmt_t;

	typedef enum logic [2:0] {
		PH_SCAN  = 3'd0,
		PH_MARK  = 3'd1,
		PH_LENHI = 3'd2,
		PH_LENLO = 3'd3,
		PH_FRAME = 3'd4,
		PH_SKIP  = 3'd5
	} jphase_t;

	typedef enum logic [1:0] {
		WALK_RUN  = 2'd0,
		WALK_OK   = 2'd1,
		WALK_BAD  = 2'd2
	} walk_t;

	function automatic logic is_frame_marker(input logic [7:0] m);
		return (m[7:4] == 4'hC) && (m != 8'hC4) && (m != 8'hC8) && (m != 8'hCC);
	endfunction

	function automatic logic [31:0] magnitude(input logic [31:0] v);
		return v[31] ? (32'd0 - v) : v;
	endfunction

endpackage

/* hdl/image_header_probe_top.sv */
// ----------------------------------------------------------------------------
// image_header_probe_top
// Image format sniffer and dimension probe.
// ----------------------------------------------------------------------------
// Takes one file byte per request, one request per cycle with no gaps needed.
// On the request flagged last_byte one result follows in the next cycle, carrying
// the format code and, where the header gives them, width and height. The
// first 30 bytes are held in registers and a JPEG segment walker tracks the
// stream; after the last byte the position and walker state return to their
// reset values so the next byte starts a new file. The result register is one
// deep: it is refilled in the same cycle it is taken, and input stalls only
// while it holds a result that is itself stalled.
// ----------------------------------------------------------------------------
module image_header_probe_top import ihp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  format_code,
	output logic        dims_found,
	output logic [31:0] image_width,
	output logic [31:0] image_height
);

	logic [5:0]  pos_q;
	logic [7:0]  hdr_q [HdrBytes];
	jphase_t     ph_q;
	logic [16:0] skip_q;
	logic [7:0]  mark_q;
	logic [15:0] seglen_q;
	logic [15:0] fh_q, fw_q;
	walk_t       walk_q;

	logic acc;
	assign in_stall = out_valid && out_stall;
	assign acc = in_valid && !in_stall;

	// Next walker state
	jphase_t     ph_d;
	logic [16:0] skip_d;
	logic [7:0]  mark_d;
	logic [15:0] seglen_d;
	logic [15:0] fh_d, fw_d;
	walk_t       walk_d;
	logic [15:0] len_full;

	always_comb begin
		ph_d = ph_q; skip_d = skip_q; mark_d = mark_q; seglen_d = seglen_q;
		fh_d = fh_q; fw_d = fw_q; walk_d = walk_q;
		len_full = seglen_q | {8'd0, data_byte};
		if (pos_q >= 6'd2 && walk_q == WALK_RUN) begin
			unique case (ph_q)
				PH_SCAN: if (data_byte == 8'hFF) ph_d = PH_MARK;
				PH_MARK: begin
					if (data_byte == 8'hFF || data_byte == 8'h01 ||
						(data_byte >= 8'hD0 && data_byte <= 8'hD9)) ph_d = PH_SCAN;
					else begin
						mark_d = data_byte; ph_d = PH_LENHI;
					end
				end
				PH_LENHI: begin
					seglen_d = {data_byte, 8'd0}; ph_d = PH_LENLO;
				end
				PH_LENLO: begin
					seglen_d = len_full;
					if (is_frame_marker(mark_q)) begin
						skip_d = '0; ph_d = PH_FRAME;
					end else if (len_full < 16'd2) walk_d = WALK_BAD;
					else if (len_full == 16'd2) ph_d = PH_SCAN;
					else begin
						skip_d = {1'b0, len_full - 16'd2}; ph_d = PH_SKIP;
					end
				end
				PH_FRAME: begin
					unique case (skip_q)
						17'd1: fh_d = {data_byte, 8'd0};
						17'd2: fh_d = fh_q | {8'd0, data_byte};
						17'd3: fw_d = {data_byte, 8'd0};
						17'd4: begin
							fw_d = fw_q | {8'd0, data_byte}; walk_d = WALK_OK;
						end
						default: ;
					endcase
					skip_d = skip_q + 17'd1;
				end
				PH_SKIP: begin
					if (skip_q > 17'd1) skip_d = skip_q - 17'd1;
					else begin
						skip_d = '0; ph_d = PH_SCAN;
					end
				end
				default: ph_d = PH_SCAN;
			endcase
		end
	end

	// Header view including the current byte
	logic [7:0] h [HdrBytes];
	logic [5:0] n;
	always_comb begin
		for (int i = 0; i < HdrBytes; i++)
			h[i] = (pos_q == 6'(i)) ? data_byte : hdr_q[i];
		n = (pos_q < PosSat) ? pos_q + 6'd1 : pos_q;
	end

	fmt_t        fmt;
	logic        fnd;
	logic [31:0] w, ht, vbits;
	always_comb begin
		fmt = FMT_NONE; fnd = 1'b0; w = '0; ht = '0;
		vbits = {h[24], h[23], h[22], h[21]};
		if (n >= 6'd8 && h[0] == 8'h89 && h[1] == 8'h50 && h[2] == 8'h4E &&
			h[3] == 8'h47 && h[4] == 8'h0D && h[5] == 8'h0A && h[6] == 8'h1A &&
			h[7] == 8'h0A) begin
			fmt = FMT_PNG;
			if (n >= 6'd24 && h[12] == "I" && h[13] == "H" && h[14] == "D" &&
				h[15] == "R") begin
				fnd = 1'b1;
				w = {h[16], h[17], h[18], h[19]};
				ht = {h[20], h[21], h[22], h[23]};
			end
		end else if (n >= 6'd3 && h[0] == 8'hFF && h[1] == 8'hD8 && h[2] == 8'hFF) begin
			fmt = FMT_JPEG;
			if (walk_d == WALK_OK) begin
				fnd = 1'b1; w = {16'd0, fw_d}; ht = {16'd0, fh_d};
			end
		end else if (n >= 6'd6 && h[0] == "G" && h[1] == "I" && h[2] == "F" &&
			h[3] == "8" && (h[4] == "7" || h[4] == "9") && h[5] == "a") begin
			fmt = FMT_GIF;
			if (n >= 6'd10) begin
				fnd = 1'b1; w = {16'd0, h[7], h[6]}; ht = {16'd0, h[9], h[8]};
			end
		end else if (n >= 6'd2 && h[0] == "B" && h[1] == "M") begin
			fmt = FMT_BMP;
			if (n >= 6'd26) begin
				fnd = 1'b1;
				w = magnitude({h[21], h[20], h[19], h[18]});
				ht = magnitude({h[25], h[24], h[23], h[22]});
			end
		end else if (n >= 6'd12 && h[0] == "R" && h[1] == "I" && h[2] == "F" &&
			h[3] == "F" && h[8] == "W" && h[9] == "E" && h[10] == "B" &&
			h[11] == "P") begin
			fmt = FMT_WEBP;
			if (n >= 6'd16 && h[12] == "V" && h[13] == "P" && h[14] == "8") begin
				if (h[15] == "X") begin
					if (n >= 6'd30) begin
						fnd = 1'b1;
						w = {8'd0, h[26], h[25], h[24]} + 32'd1;
						ht = {8'd0, h[29], h[28], h[27]} + 32'd1;
					end
				end else if (h[15] == " ") begin
					if (n >= 6'd30) begin
						fnd = 1'b1;
						w = {18'd0, h[27][5:0], h[26]};
						ht = {18'd0, h[29][5:0], h[28]};
					end
				end else if (h[15] == "L") begin
					if (n >= 6'd25 && h[20] == 8'h2F) begin
						fnd = 1'b1;
						w = {18'd0, vbits[13:0]} + 32'd1;
						ht = {18'd0, vbits[27:14]} + 32'd1;
					end
				end
			end
		end else if (n >= 6'd4 && ((h[0] == "I" && h[1] == "I" && h[2] == 8'h2A &&
			h[3] == 8'h00) || (h[0] == "M" && h[1] == "M" && h[2] == 8'h00 &&
			h[3] == 8'h2A))) begin
			fmt = FMT_TIFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; ph_q <= PH_SCAN; skip_q <= '0; mark_q <= '0;
			seglen_q <= '0; fh_q <= '0; fw_q <= '0; walk_q <= WALK_RUN;
		end else if (acc) begin
			if (last_byte) begin
				pos_q <= '0; ph_q <= PH_SCAN; skip_q <= '0; mark_q <= '0;
				seglen_q <= '0; fh_q <= '0; fw_q <= '0; walk_q <= WALK_RUN;
			end else begin
				pos_q <= n; ph_q <= ph_d; skip_q <= skip_d; mark_q <= mark_d;
				seglen_q <= seglen_d; fh_q <= fh_d; fw_q <= fw_d; walk_q <= walk_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && pos_q < 6'(HdrBytes)) hdr_q[pos_q[4:0]] <= data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (!in_stall) out_valid <= acc && last_byte;
	end

	always_ff @(posedge clk) begin
		if (acc && last_byte) begin
			format_code <= fmt;
			dims_found <= fnd;
			image_width <= fnd ? w : 32'd0;
			image_height <= fnd ? ht : 32'd0;
		end
	end

	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n) pos_q <= PosSat)
		else $error("byte position beyond saturation");
	a_reset_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		acc && last_byte |=> pos_q == 6'd0 && walk_q == WALK_RUN)
		else $error("state not cleared after last byte");
	a_nodims_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !dims_found |-> image_width == 32'd0 && image_height == 32'd0)
		else $error("dimensions without dims_found");
	a_walk_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		walk_q != WALK_RUN && !(acc && last_byte) |=> $stable(walk_q))
		else $error("walker left a finished state");

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the image header probe.
// ----------------------------------------------------------------------------
// Streams whole files one byte per request and predicts the format, the
// dimension flag, width and height of each file from its own model of the
// header store and JPEG segment walk. Directed files cover every format and
// its short and special forms, then random files of each kind with random
// content are mixed with noise, under random gaps, stalls and back-pressure.
// ----------------------------------------------------------------------------
module testbench;
	import ihp_pkg::*;

	typedef struct packed {
		fmt_t        fmt;
		logic        found;
		logic [31:0] w;
		logic [31:0] h;
	} probe_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'd0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  format_code;
	logic        dims_found;
	logic [31:0] image_width;
	logic [31:0] image_height;

	image_header_probe_top u_dut (.*);

	always #2 clk = ~clk;

	probe_res_t  expected_q[$];
	int          errors = 0;
	int          files_sent = 0;
	int          bytes_sent = 0;
	int          results_seen = 0;
	longint      cycle_count = 0;
	int          idle_pct = 18;
	int          hold_cycles = 0;

	// predictor state
	logic [5:0]  m_pos;
	logic [7:0]  m_hdr[30];
	jphase_t     m_phase;
	logic [16:0] m_skip;
	logic [7:0]  m_mark;
	logic [15:0] m_len;
	logic [15:0] m_fh;
	logic [15:0] m_fw;
	walk_t       m_walk;

	function automatic void model_clear();
		m_pos = 6'd0;
		foreach (m_hdr[i]) m_hdr[i] = 8'd0;
		m_phase = PH_SCAN;
		m_skip = '0;
		m_mark = '0;
		m_len = '0;
		m_fh = '0;
		m_fw = '0;
		m_walk = WALK_RUN;
	endfunction

	function automatic logic [31:0] hb(int k);
		return (k < HdrBytes) ? {24'd0, m_hdr[k]} : 32'd0;
	endfunction

	function automatic logic [31:0] le16(int k);
		return hb(k) | (hb(k + 1) << 8);
	endfunction

	function automatic logic [31:0] le32(int k);
		return le16(k) | (le16(k + 2) << 16);
	endfunction

	function automatic logic [31:0] be32(int k);
		return (hb(k) << 24) | (hb(k + 1) << 16) | (hb(k + 2) << 8) | hb(k + 3);
	endfunction

	function automatic logic hdr_match(int k, string s);
		for (int i = 0; i < s.len(); i++)
			if (hb(k + i) != {24'd0, s[i]}) return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [31:0] abs32(logic [31:0] v);
		return v[31] ? (32'd0 - v) : v;
	endfunction

	function automatic logic frame_marker(logic [7:0] m);
		return m >= 8'hC0 && m <= 8'hCF && m != 8'hC4 && m != 8'hC8 && m != 8'hCC;
	endfunction

	function automatic void walk_byte(logic [7:0] b);
		if (m_walk != WALK_RUN) return;
		case (m_phase)
			PH_SCAN: if (b == 8'hFF) m_phase = PH_MARK;
			PH_MARK: begin
				if (b == 8'hFF || b == 8'h01 || (b >= 8'hD0 && b <= 8'hD9))
					m_phase = PH_SCAN;
				else begin
					m_mark = b;
					m_phase = PH_LENHI;
				end
			end
			PH_LENHI: begin
				m_len = {b, 8'd0};
				m_phase = PH_LENLO;
			end
			PH_LENLO: begin
				m_len = m_len | {8'd0, b};
				if (frame_marker(m_mark)) begin
					m_skip = '0;
					m_phase = PH_FRAME;
				end else if (m_len < 16'd2) m_walk = WALK_BAD;
				else if (m_len == 16'd2) m_phase = PH_SCAN;
				else begin
					m_skip = {1'b0, m_len} - 17'd2;
					m_phase = PH_SKIP;
				end
			end
			PH_FRAME: begin
				case (m_skip)
					17'd1: m_fh = {b, 8'd0};
					17'd2: m_fh = m_fh | {8'd0, b};
					17'd3: m_fw = {b, 8'd0};
					17'd4: begin
						m_fw = m_fw | {8'd0, b};
						m_walk = WALK_OK;
					end
					default: ;
				endcase
				m_skip = m_skip + 17'd1;
			end
			PH_SKIP: begin
				if (m_skip > 0) m_skip = m_skip - 17'd1;
				if (m_skip == 0) m_phase = PH_SCAN;
			end
			default: m_phase = PH_SCAN;
		endcase
	endfunction

	function automatic void predict_probe(logic [7:0] b, logic last);
		probe_res_t r;
		int n;
		logic [31:0] bits;
		if (m_pos < HdrBytes) m_hdr[m_pos] = b;
		if (m_pos >= 2) walk_byte(b);
		if (m_pos < PosSat) m_pos = m_pos + 6'd1;
		if (!last) return;
		n = m_pos;
		r = '{FMT_NONE, 1'b0, 32'd0, 32'd0};
		if (n >= 8 && hb(0) == 32'h89 && hdr_match(1, "PNG") && be32(4) == 32'h0D0A1A0A) begin
			r.fmt = FMT_PNG;
			if (n >= 24 && hdr_match(12, "IHDR")) r = '{FMT_PNG, 1'b1, be32(16), be32(20)};
		end else if (n >= 3 && hb(0) == 32'hFF && hb(1) == 32'hD8 && hb(2) == 32'hFF) begin
			r.fmt = FMT_JPEG;
			if (m_walk == WALK_OK) r = '{FMT_JPEG, 1'b1, {16'd0, m_fw}, {16'd0, m_fh}};
		end else if (n >= 6 && (hdr_match(0, "GIF87a") || hdr_match(0, "GIF89a"))) begin
			r.fmt = FMT_GIF;
			if (n >= 10) r = '{FMT_GIF, 1'b1, le16(6), le16(8)};
		end else if (n >= 2 && hdr_match(0, "BM")) begin
			r.fmt = FMT_BMP;
			if (n >= 26) r = '{FMT_BMP, 1'b1, abs32(le32(18)), abs32(le32(22))};
		end else if (n >= 12 && hdr_match(0, "RIFF") && hdr_match(8, "WEBP")) begin
			r.fmt = FMT_WEBP;
			if (n >= 16) begin
				if (hdr_match(12, "VP8X")) begin
					if (n >= 30)
						r = '{FMT_WEBP, 1'b1,
							(hb(24) | (hb(25) << 8) | (hb(26) << 16)) + 32'd1,
							(hb(27) | (hb(28) << 8) | (hb(29) << 16)) + 32'd1};
				end else if (hdr_match(12, "VP8 ")) begin
					if (n >= 30)
						r = '{FMT_WEBP, 1'b1, le16(26) & 32'h3FFF, le16(28) & 32'h3FFF};
				end else if (hdr_match(12, "VP8L")) begin
					if (n >= 25 && hb(20) == 32'h2F) begin
						bits = le32(21);
						r = '{FMT_WEBP, 1'b1, (bits & 32'h3FFF) + 32'd1,
							((bits >> 14) & 32'h3FFF) + 32'd1};
					end
				end
			end
		end else if (n >= 4 && ((hdr_match(0, "II") && hb(2) == 32'h2A && hb(3) == 32'h00) ||
				(hdr_match(0, "MM") && hb(2) == 32'h00 && hb(3) == 32'h2A)))
			r.fmt = FMT_TIFF;
		expected_q.push_back(r);
		model_clear();
	endfunction

	// sender: one request, held until taken
	task automatic send_byte(logic [7:0] b, logic last);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_probe(b, last);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_file(logic [7:0] f[$]);
		foreach (f[i]) send_byte(f[i], i == f.size() - 1);
		files_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// file builders
	function automatic void put_str(ref logic [7:0] f[$], input string s);
		for (int i = 0; i < s.len(); i++) f.push_back(s[i]);
	endfunction

	function automatic void put_le(ref logic [7:0] f[$], input logic [31:0] v, input int n);
		for (int i = 0; i < n; i++) f.push_back(v[8*i +: 8]);
	endfunction

	function automatic void put_be(ref logic [7:0] f[$], input logic [31:0] v, input int n);
		for (int i = n - 1; i >= 0; i--) f.push_back(v[8*i +: 8]);
	endfunction

	function automatic void put_rand(ref logic [7:0] f[$], input int n);
		repeat (n) f.push_back(8'($urandom));
	endfunction

	function automatic void mk_png(ref logic [7:0] f[$], input logic [31:0] w, h, input int tail);
		put_be(f, 32'h89504E47, 4);
		put_be(f, 32'h0D0A1A0A, 4);
		put_be(f, 32'd13, 4);
		put_str(f, "IHDR");
		put_be(f, w, 4);
		put_be(f, h, 4);
		put_rand(f, tail);
	endfunction

	function automatic void mk_gif(ref logic [7:0] f[$], input logic [15:0] w, h);
		put_str(f, ($urandom_range(1)) ? "GIF89a" : "GIF87a");
		put_le(f, {16'd0, w}, 2);
		put_le(f, {16'd0, h}, 2);
		put_rand(f, $urandom_range(6));
	endfunction

	function automatic void mk_bmp(ref logic [7:0] f[$], input logic [31:0] w, h);
		put_str(f, "BM");
		put_rand(f, 16);
		put_le(f, w, 4);
		put_le(f, h, 4);
		put_rand(f, $urandom_range(8));
	endfunction

	function automatic void mk_webp(ref logic [7:0] f[$], input int kind);
		put_str(f, "RIFF");
		put_rand(f, 4);
		put_str(f, "WEBP");
		case (kind)
			0: put_str(f, "VP8X");
			1: put_str(f, "VP8 ");
			2: put_str(f, "VP8L");
			default: put_rand(f, 4);
		endcase
		put_rand(f, 4);
		if (kind == 2 && $urandom_range(3) != 0) f.push_back(8'h2F);
		while (f.size() < 30) f.push_back(8'($urandom));
		put_rand(f, $urandom_range(4));
	endfunction

	function automatic void mk_jpeg(ref logic [7:0] f[$], input logic [7:0] sof,
			input logic [15:0] w, h);
		int segs;
		int len;
		put_be(f, 32'hFFD8, 2);
		segs = $urandom_range(3);
		repeat (segs) begin
			case ($urandom_range(3))
				0: put_be(f, {16'd0, 8'hFF, 8'hD0 + 8'($urandom_range(9))}, 2);
				1: put_be(f, 32'hFFFF01, 3);
				default: begin
					len = $urandom_range(2, 12);
					put_be(f, {16'd0, 8'hFF, 8'hE0 + 8'($urandom_range(15))}, 2);
					put_be(f, len, 2);
					put_rand(f, len - 2);
				end
			endcase
		end
		put_be(f, {16'd0, 8'hFF, sof}, 2);
		put_be(f, 32'd17, 2);
		f.push_back(8'd8);
		put_be(f, {16'd0, h}, 2);
		put_be(f, {16'd0, w}, 2);
		put_rand(f, $urandom_range(6));
	endfunction

	// checker
	always @(posedge clk) begin
		probe_res_t e;
		cycle_count <= cycle_count + 1;
		if (arst_n && out_valid && !out_stall) begin
			results_seen <= results_seen + 1;
			if (expected_q.size() == 0) begin
				$error("unexpected result fmt=%0d", format_code);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (format_code !== e.fmt) begin
					$error("format_code exp %0d got %0d", e.fmt, format_code);
					errors++;
				end
				if (dims_found !== e.found) begin
					$error("dims_found exp %0d got %0d", e.found, dims_found);
					errors++;
				end
				if (image_width !== e.w) begin
					$error("image_width exp %0h got %0h", e.w, image_width);
					errors++;
				end
				if (image_height !== e.h) begin
					$error("image_height exp %0h got %0h", e.h, image_height);
					errors++;
				end
			end
		end
		if (cycle_count > 400000) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// receiver stall, with an optional long hold
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < idle_pct);
	end

	task automatic test_directed();
		logic [7:0] f[$];
		f = {}; mk_png(f, 32'hFFFFFFFF, 32'h80000001, 2); send_file(f);
		f = {}; mk_png(f, 32'd0, 32'd1, 0); send_file(f);
		f = {}; mk_png(f, 32'd1, 32'd1, 0); f = f[0:20]; send_file(f);
		f = {}; mk_png(f, 32'd1, 32'd1, 0); f[13] = 8'h00; send_file(f);
		f = {}; mk_jpeg(f, 8'hC0, 16'hFFFF, 16'h0001); send_file(f);
		f = {}; mk_jpeg(f, 8'hCF, 16'h1234, 16'hABCD); send_file(f);
		f = {}; mk_jpeg(f, 8'hC2, 16'd640, 16'd480); f = f[0:f.size() - 9]; send_file(f);
		f = {8'hFF, 8'hD8, 8'hFF, 8'hE1, 8'h00, 8'h01, 8'hFF, 8'hC0, 8'h00};
		send_file(f);
		f = {}; mk_gif(f, 16'hFFFF, 16'h0000); send_file(f);
		f = {}; put_str(f, "GIF89a"); put_rand(f, 2); send_file(f);
		f = {}; mk_bmp(f, 32'h80000000, 32'hFFFFFFFF); send_file(f);
		f = {}; mk_bmp(f, 32'h7FFFFFFF, 32'd5); send_file(f);
		f = {}; put_str(f, "BM"); send_file(f);
		for (int k = 0; k < 4; k++) begin
			f = {}; mk_webp(f, k); send_file(f);
		end
		f = {}; put_str(f, "II"); put_be(f, 32'h2A00, 2); send_file(f);
		f = {}; put_str(f, "MM"); put_be(f, 32'h002A, 2); send_file(f);
		f = {8'h00}; send_file(f);
		f = {8'hFF}; send_file(f);
		drain();
	endtask

	task automatic test_random(int n_bytes);
		logic [7:0] f[$];
		int stop;
		stop = bytes_sent + n_bytes;
		while (bytes_sent < stop) begin
			f = {};
			case ($urandom_range(9))
				0: mk_png(f, $urandom, $urandom, $urandom_range(4));
				1, 2: mk_jpeg(f, 8'hC0 + 8'($urandom_range(15)), 16'($urandom),
					16'($urandom));
				3: mk_gif(f, 16'($urandom), 16'($urandom));
				4: mk_bmp(f, $urandom, $urandom);
				5: mk_webp(f, $urandom_range(3));
				6: begin
					put_str(f, $urandom_range(1) ? "II" : "MM");
					put_rand(f, $urandom_range(2, 6));
				end
				7: put_rand(f, $urandom_range(1, 40));
				default: begin
					mk_jpeg(f, 8'hC0, 16'($urandom), 16'($urandom));
					f = f[0:$urandom_range(2, f.size() - 1)];
				end
			endcase
			if ($urandom_range(7) == 0 && f.size() > 1)
				f[$urandom_range(f.size() - 1)] = 8'($urandom);
			send_file(f);
		end
		drain();
	endtask

	task automatic test_backpressure();
		hold_cycles = 60;
		test_random(150);
	endtask

	task automatic test_no_idle();
		idle_pct = 0;
		test_random(300);
		idle_pct = 18;
	endtask

	initial begin
		model_clear();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(700);
		test_backpressure();
		test_no_idle();
		drain();
		$display("covered %0d files, %0d bytes, %0d results", files_sent, bytes_sent,
			results_seen);
		$display("all formats, short files, JPEG walk cases, stalls and gaps");
		if (errors == 0 && expected_q.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
